// ===== sv/sts_pkg.sv =====
// sts_pkg: shared constants and controller/datapath types for the successor search
`timescale 1ns / 1ps
package sts_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = 11;
    localparam int SLOT_W      = 10;
    localparam int DATA_W      = 32;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_ENTRY_COUNT = 1'b0;

    typedef struct packed {
        logic write;
        logic start;
        logic probe;
        logic step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic len_zero;
        logic step_done;
    } t_status;

endpackage

// ===== sv/sts_if.sv =====
// sts_if: valid/ready channel interfaces for input items and results
`timescale 1ns / 1ps
interface sts_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [9:0]         slot;
    logic signed [31:0] entry_value;
    logic signed [31:0] key;

    modport source (output valid, operation, slot, entry_value, key, input ready);
    modport sink   (input valid, operation, slot, entry_value, key, output ready);
endinterface

interface sts_out_if;
    logic               valid;
    logic               ready;
    logic               has_successor;
    logic signed [31:0] successor_value;

    modport source (output valid, has_successor, successor_value, input ready);
    modport sink   (input valid, has_successor, successor_value, output ready);
endinterface

// ===== sv/sts_ctrl.sv =====
// sts_ctrl: sequencer for table writes and the halving search of a query
`timescale 1ns / 1ps
module sts_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_operation,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    input  sts_pkg::t_status i_status,
    output sts_pkg::t_cmd   o_cmd
);
    import sts_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PROBE  = 2'd1;
    localparam logic [1:0] ST_CMP    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_operation == OP_QUERY) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_PROBE;
                    end else begin
                        o_cmd.write = 1'b1;
                    end
                end
            end
            ST_PROBE: begin
                if (i_status.len_zero) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.probe = 1'b1;
                    n_state     = ST_CMP;
                end
            end
            ST_CMP: begin
                o_cmd.step = 1'b1;
                if (i_status.step_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // result register free or being emptied this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/sts_dpath.sv =====
// sts_dpath: table memory, search window registers, compare and result register
`timescale 1ns / 1ps
module sts_dpath (
    input  logic                         i_clk,
    input  sts_pkg::t_cmd                i_cmd,
    output sts_pkg::t_status             o_status,
    input  logic [sts_pkg::COUNT_W-1:0]  i_entry_count,
    input  logic [sts_pkg::SLOT_W-1:0]   i_slot,
    input  logic signed [sts_pkg::DATA_W-1:0] i_entry_value,
    input  logic signed [sts_pkg::DATA_W-1:0] i_key,
    output logic                         o_has_successor,
    output logic signed [sts_pkg::DATA_W-1:0] o_successor_value
);
    import sts_pkg::*;

    logic signed [DATA_W-1:0] r_table [TABLE_DEPTH];
    logic signed [DATA_W-1:0] r_rdata;
    logic signed [DATA_W-1:0] r_key;
    logic [COUNT_W-1:0]       r_base;
    logic [COUNT_W-1:0]       r_len;
    logic                     r_found;
    logic signed [DATA_W-1:0] r_best;
    logic                     r_res_has;
    logic signed [DATA_W-1:0] r_res_val;

    logic [COUNT_W-1:0] n_base;
    logic [COUNT_W-1:0] n_len;
    logic [COUNT_W-1:0] mid;
    logic [COUNT_W-1:0] pos_cur;
    logic [COUNT_W-1:0] pos_next;
    logic [COUNT_W-1:0] rd_pos;
    logic [COUNT_W-1:0] count_sat;
    logic               key_lt;
    logic               key_gt;
    logic               key_eq;
    logic               rd_en;
    logic               wr_en;

    assign mid     = r_len >> 1;
    assign pos_cur = r_base + mid;
    assign key_lt  = r_key < r_rdata;
    assign key_gt  = r_key > r_rdata;
    assign key_eq  = !key_lt && !key_gt;

    assign count_sat = (i_entry_count > COUNT_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH)
                                                               : i_entry_count;

    always_comb begin
        n_base = r_base;
        n_len  = r_len;
        if (i_cmd.start) begin
            n_base = '0;
            n_len  = count_sat;
        end else if (i_cmd.step) begin
            if (key_lt) begin
                n_len = mid;
            end else if (key_gt) begin
                n_base = pos_cur + COUNT_W'(1);
                n_len  = r_len - mid - COUNT_W'(1);
            end
        end
    end

    // next probe address follows straight from the updated window
    assign pos_next = n_base + (n_len >> 1);
    assign rd_pos   = i_cmd.probe ? pos_cur : pos_next;
    assign rd_en    = i_cmd.probe || (i_cmd.step && !o_status.step_done);
    assign wr_en    = i_cmd.write && ({1'b0, i_slot} < COUNT_W'(TABLE_DEPTH));

    assign o_status.len_zero  = (r_len == '0);
    assign o_status.step_done = key_eq || (n_len == '0);

    // single port: writes only in idle, reads only while searching
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[i_slot[ADDR_W-1:0]] <= i_entry_value;
        end
        if (rd_en) begin
            r_rdata <= r_table[rd_pos[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_len  <= n_len;
        if (i_cmd.start) begin
            r_key   <= i_key;
            r_found <= 1'b0;
            r_best  <= '0;
        end else if (i_cmd.step && !key_gt) begin
            r_found <= 1'b1;
            r_best  <= r_rdata;
        end
        if (i_cmd.emit) begin
            r_res_has <= r_found;
            r_res_val <= r_found ? r_best : '0;
        end
    end

    assign o_has_successor   = r_res_has;
    assign o_successor_value = r_res_val;

endmodule

// ===== sv/sorted_table_successor_search.sv =====
// Query: the halving search makes one table read per probe, at most floor(log2(n)) + 1 reads,
// n being entry_count capped at the table depth, so up to 11 reads for a full 1024-entry table.
// One read of the single-port table memory per probe sets the pace; a query blocks input
// until its result is loaded, longer while an earlier result stalls in the output register.
// Write items leave the input ready and may follow back to back.
// Synchronous active-low reset clears entry_count and control; table contents stay undefined.
`timescale 1ns / 1ps
module sorted_table_successor_search (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    sts_in_if.sink                           i_in,
    sts_out_if.source                        o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sts_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sts_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sts_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import sts_pkg::*;

    logic [COUNT_W-1:0] r_entry_count;
    t_cmd               cmd;
    t_status            status;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ENTRY_COUNT);
    assign prdata = (paddr[2] == REG_ENTRY_COUNT)
                    ? {{(APB_DATA_W-COUNT_W){1'b0}}, r_entry_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (cfg_wr) begin
            r_entry_count <= pwdata[COUNT_W-1:0];
        end
    end

    sts_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in.valid),
        .i_in_operation (i_in.operation),
        .o_in_ready     (i_in.ready),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .i_status       (status),
        .o_cmd          (cmd)
    );

    sts_dpath u_dpath (
        .i_clk             (i_clk),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_entry_count     (r_entry_count),
        .i_slot            (i_in.slot),
        .i_entry_value     (i_in.entry_value),
        .i_key             (i_in.key),
        .o_has_successor   (o_out.has_successor),
        .o_successor_value (o_out.successor_value)
    );

endmodule

// ===== sv/sts_checker.sv =====
// sts_checker: port-level assertions for the successor search, bound to the top level
`timescale 1ns / 1ps
module sts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_operation,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_has,
    input logic [31:0] i_out_value
);
    import sts_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value)
            && $stable(i_out_has))
        else $error("result changed while stalled");

    // a write transfer never produces a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_operation == OP_WRITE |=> !$rose(i_out_valid))
        else $error("result appeared after a write transfer");

    // input blocked while a query is searched
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_operation == OP_QUERY |=> !i_in_ready)
        else $error("input taken during a query search");

    // no successor means zero value
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_has |-> i_out_value == '0)
        else $error("nonzero value with no successor");

endmodule

bind sorted_table_successor_search sts_checker u_sts_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_operation (i_in.operation),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_has      (o_out.has_successor),
    .i_out_value    (o_out.successor_value)
);

// ===== verif/sorted_table_successor_search_test.sv =====
// testbench for the sorted-table successor search: directed and random traffic checked against a local predictor
`timescale 1ns / 1ps
module sorted_table_successor_search_test;
    import sts_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int ITEM_TARGET  = 1900;
    localparam int SETTLE_CYCLES = 24;   // longest query makes up to 11 table reads
    localparam int END_CYCLES   = 40;
    localparam int LONG_HOLD    = 200;
    localparam int SORTED_WINDOW = 64;
    localparam int ENTRY_COUNT_ADDR = 4 * int'(REG_ENTRY_COUNT);

    localparam logic signed [DATA_W-1:0] MIN_VALUE = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MAX_VALUE = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic                     operation;
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] key;
    } table_request_t;

    typedef struct packed {
        logic                     has_successor;
        logic signed [DATA_W-1:0] successor_value;
    } successor_t;

    typedef enum logic [1:0] {RX_STREAM, RX_CHOPPY, RX_SLOW} rx_pattern_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sts_in_if  in_if ();
    sts_out_if out_if ();

    logic           drv_valid = 1'b0;
    table_request_t drv_item  = '0;
    logic           rx_ready  = 1'b0;
    logic           in_fire   = 1'b0;

    assign in_if.valid       = drv_valid;
    assign in_if.operation   = drv_item.operation;
    assign in_if.slot        = drv_item.slot;
    assign in_if.entry_value = drv_item.entry_value;
    assign in_if.key         = drv_item.key;
    assign out_if.ready      = rx_ready;

    sorted_table_successor_search dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    table_request_t queued_requests[$];
    successor_t     awaited_successors[$];

    // what the block holds, updated as transfers are accepted
    logic signed [DATA_W-1:0] mirror_table [TABLE_DEPTH];
    logic [COUNT_W-1:0]       mirror_count = '0;

    // what the stimulus has planned so far, used to pick keys
    logic signed [DATA_W-1:0] planned_table [TABLE_DEPTH];

    int  request_total = 0;
    int  error_count   = 0;
    int  cycle_count   = 0;
    bit  long_hold_tog = 1'b0;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    function automatic successor_t find_successor(input logic signed [DATA_W-1:0] key);
        successor_t  res;
        int unsigned base;
        int unsigned span;
        int unsigned mid;
        logic signed [DATA_W-1:0] probe;
        res  = '0;
        base = 0;
        span = (mirror_count > TABLE_DEPTH) ? TABLE_DEPTH : mirror_count;
        while (span > 0) begin
            mid   = span / 2;
            probe = mirror_table[base + mid];
            if (key < probe) begin
                res  = '{1'b1, probe};
                span = mid;
            end else if (key > probe) begin
                base = base + mid + 1;
                span = span - (mid + 1);
            end else begin
                res  = '{1'b1, probe};
                span = 0;
            end
        end
        return res;
    endfunction

    // sender: bursts of back-to-back items separated by random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(negedge i_clk) begin : request_driver
        table_request_t next_item;
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else if (!drv_valid || in_fire) begin
            if (gap_left > 0) begin
                gap_left  <= gap_left - 1;
                drv_valid <= 1'b0;
            end else if (queued_requests.size() > 0) begin
                next_item = queued_requests.pop_front();
                drv_item  <= next_item;
                drv_valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // receiver: changing stall pattern, plus one long hold on request
    rx_pattern_t rx_pattern     = RX_STREAM;
    int unsigned pattern_left   = 0;
    int unsigned hold_left      = 0;
    bit          long_hold_seen = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
        end else if (long_hold_tog != long_hold_seen) begin
            long_hold_seen <= long_hold_tog;
            hold_left      <= LONG_HOLD;
            rx_ready       <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rx_ready  <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                rx_pattern   <= rx_pattern_t'($urandom_range(0, 2));
                pattern_left <= $urandom_range(16, 96);
            end else begin
                pattern_left <= pattern_left - 1;
            end
            case (rx_pattern)
                RX_STREAM: rx_ready <= 1'b1;
                RX_CHOPPY: rx_ready <= 1'($urandom_range(0, 1));
                default:   rx_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : transfer_monitor
        successor_t want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= drv_valid && in_if.ready;
            if (out_if.valid && rx_ready) begin
                if (awaited_successors.size() == 0) begin
                    error_count++;
                    $display("%0t: result with none awaited: expected nothing, actual %0b / %0d",
                             $time, out_if.has_successor, out_if.successor_value);
                end else begin
                    want = awaited_successors.pop_front();
                    if (out_if.has_successor !== want.has_successor) begin
                        error_count++;
                        $display("%0t: has_successor expected %0b actual %0b",
                                 $time, want.has_successor, out_if.has_successor);
                    end
                    if (out_if.successor_value !== want.successor_value) begin
                        error_count++;
                        $display("%0t: successor_value expected %0d actual %0d",
                                 $time, want.successor_value, out_if.successor_value);
                    end
                end
            end
            if (drv_valid && in_if.ready) begin
                if (drv_item.operation == OP_WRITE)
                    mirror_table[drv_item.slot] = drv_item.entry_value;
                else
                    awaited_successors.push_back(find_successor(drv_item.key));
            end
        end
    end

    task automatic write_entry(input int unsigned slot, input logic signed [DATA_W-1:0] value);
        table_request_t req;
        req.operation   = OP_WRITE;
        req.slot        = slot[SLOT_W-1:0];
        req.entry_value = value;
        req.key         = $urandom;
        queued_requests.push_back(req);
        planned_table[slot] = value;
        request_total++;
    endtask

    task automatic ask_successor(input logic signed [DATA_W-1:0] key);
        table_request_t req;
        req.operation   = OP_QUERY;
        req.slot        = SLOT_W'($urandom);
        req.entry_value = $urandom;
        req.key         = key;
        queued_requests.push_back(req);
        request_total++;
    endtask

    // ascending values from the bottom of the range up to upper, with some repeats
    task automatic write_sorted_run(input int unsigned n, input longint upper);
        longint cur;
        longint step_max;
        int unsigned i;
        cur      = longint'(MIN_VALUE);
        step_max = (upper - longint'(MIN_VALUE)) * 2 / n;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) != 0)
                cur = cur + (longint'({$urandom}) % (step_max + 1));
            if (cur > upper)
                cur = upper;
            write_entry(i, cur[DATA_W-1:0]);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_key(input int unsigned in_use);
        int unsigned idx;
        logic signed [DATA_W-1:0] near;
        if (in_use == 0)
            return $urandom;
        idx  = $urandom_range(0, in_use - 1);
        near = planned_table[idx];
        case ($urandom_range(0, 9))
            0, 1, 2: return near;
            3, 4:    return near + 1;
            5, 6:    return near - 1;
            7:       return $urandom;
            default: return $urandom_range(0, 1) ? MIN_VALUE : MAX_VALUE;
        endcase
    endfunction

    task automatic query_burst(input int unsigned n, input int unsigned in_use);
        int unsigned i;
        for (i = 0; i < n; i++)
            ask_successor(pick_key(in_use));
    endtask

    task automatic wait_quiet();
        while (queued_requests.size() != 0 || drv_valid || awaited_successors.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_entry_count(input int unsigned value);
        wait_quiet();
        // writes give no result, so the last one may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ENTRY_COUNT_ADDR[APB_ADDR_W-1:0];
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        mirror_count = value[COUNT_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_random_phase(input bit with_long_hold);
        int unsigned count;
        int unsigned in_use;
        int unsigned queries;
        int unsigned noise_span;
        int unsigned i;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            count = 0;
        else if (pick == 1)
            count = $urandom_range(TABLE_DEPTH + 1, 2047);
        else if (pick <= 4)
            count = $urandom_range(SORTED_WINDOW + 1, TABLE_DEPTH);
        else
            count = $urandom_range(1, SORTED_WINDOW);
        in_use = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
        // keep the whole in-use range ascending where the upper part is left alone
        if (in_use > SORTED_WINDOW)
            write_sorted_run(SORTED_WINDOW, planned_table[SORTED_WINDOW]);
        else if (in_use > 0)
            write_sorted_run(in_use,
                             $urandom_range(0, 1) ? MAX_VALUE : planned_table[in_use]);
        set_entry_count(count);
        noise_span = (in_use > SORTED_WINDOW) ? SORTED_WINDOW : in_use;
        queries    = $urandom_range(8, 40);
        for (i = 0; i < queries; i++) begin
            // occasional stray write breaks the ordering
            if (noise_span > 0 && $urandom_range(0, 15) == 0)
                write_entry($urandom_range(0, noise_span - 1), $urandom);
            ask_successor(pick_key(in_use));
        end
        if (with_long_hold)
            long_hold_tog = ~long_hold_tog;
    endtask

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("sorted_table_successor_search: mismatch");
        $finish;
    end

    initial begin
        int phase;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table
        set_entry_count(0);
        ask_successor(MIN_VALUE);
        ask_successor(MAX_VALUE);

        write_entry(0, MIN_VALUE);
        write_entry(1, -1000);
        write_entry(2, -1);
        write_entry(3, 0);
        write_entry(4, 1);
        write_entry(5, 77);
        write_entry(6, 1000);
        write_entry(7, MAX_VALUE);
        set_entry_count(8);
        ask_successor(MIN_VALUE);
        ask_successor(MAX_VALUE);
        ask_successor(0);
        ask_successor(2);
        ask_successor(-999);
        ask_successor(1001);
        ask_successor(MIN_VALUE + 1);

        // keys at and above the top entry in use
        set_entry_count(7);
        ask_successor(MAX_VALUE);
        ask_successor(1000);

        set_entry_count(1);
        ask_successor(5);
        ask_successor(MIN_VALUE);

        // out-of-order table
        write_entry(3, MAX_VALUE);
        set_entry_count(8);
        ask_successor(5);
        ask_successor(-5);

        // full table, then a count beyond the table depth and one just below it
        write_sorted_run(TABLE_DEPTH, MAX_VALUE);
        set_entry_count(TABLE_DEPTH);
        query_burst(30, TABLE_DEPTH);
        set_entry_count(2047);
        query_burst(20, TABLE_DEPTH);
        set_entry_count(TABLE_DEPTH - 1);
        query_burst(15, TABLE_DEPTH - 1);

        phase = 0;
        while (request_total < ITEM_TARGET) begin
            run_random_phase(phase == 2);
            phase++;
        end

        wait_quiet();
        repeat (END_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("sorted_table_successor_search: match");
        else
            $display("sorted_table_successor_search: mismatch");
        $finish;
    end

endmodule
